// File: sv/hhp_pkg.sv
// Shared types and constants for the heater hysteresis/profile block.
package hhp_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SUN_ON_TEMP        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SUN_OFF_TEMP       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ECLIPSE_ON_TEMP    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ECLIPSE_OFF_TEMP   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_POWER_THRESHOLD_MW = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SWITCH_COUNT       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TUMBLE_TIME_S      = 3'd6;

    // Register reset values
    localparam logic signed [7:0] RST_SUN_ON_TEMP        = 8'sd0;
    localparam logic signed [7:0] RST_SUN_OFF_TEMP       = 8'sd5;
    localparam logic signed [7:0] RST_ECLIPSE_ON_TEMP    = 8'sd5;
    localparam logic signed [7:0] RST_ECLIPSE_OFF_TEMP   = 8'sd10;
    localparam logic [15:0]       RST_POWER_THRESHOLD_MW = 16'd1000;
    localparam logic [7:0]        RST_SWITCH_COUNT       = 8'd10;
    localparam logic [15:0]       RST_TUMBLE_TIME_S      = 16'd60;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic signed [7:0] temperature;
        logic [15:0]       power_mw;
        logic [31:0]       time_s;
    } hhp_in_t;

    typedef struct packed {
        logic heater_enable;
        logic sunshine_profile;
    } hhp_out_t;

    typedef struct packed {
        logic signed [7:0] sun_on_temp;
        logic signed [7:0] sun_off_temp;
        logic signed [7:0] eclipse_on_temp;
        logic signed [7:0] eclipse_off_temp;
        logic [15:0]       power_threshold_mw;
        logic [7:0]        switch_count;
        logic [15:0]       tumble_time_s;
    } hhp_cfg_t;

    typedef struct packed {
        logic        heater_switch;
        logic        profile_bit;
        logic        window_armed;
        logic [31:0] window_start;
        logic [7:0]  crossing_count;
    } hhp_state_t;

endpackage

// File: sv/hhp_update.sv
// Per-item profile tracking and hysteresis thermostat, pure combinational.
module hhp_update (
    input  hhp_pkg::hhp_cfg_t   cfg,
    input  hhp_pkg::hhp_state_t state_cur,
    input  hhp_pkg::hhp_in_t    item,
    output hhp_pkg::hhp_state_t state_nxt,
    output hhp_pkg::hhp_out_t   result
);

    logic              crossing;
    logic [31:0]       elapsed;
    logic              window_expired;
    logic [7:0]        count_inc;
    logic              flip;
    logic              profile_new;
    logic signed [7:0] temp;
    logic signed [7:0] on_t;
    logic signed [7:0] off_t;
    logic              heater_new;

    assign crossing = state_cur.profile_bit ? (item.power_mw < cfg.power_threshold_mw)
                                            : (item.power_mw >= cfg.power_threshold_mw);
    assign elapsed        = item.time_s - state_cur.window_start;
    assign window_expired = elapsed >= {16'd0, cfg.tumble_time_s};
    assign count_inc      = (state_cur.crossing_count == hhp_pkg::COUNT_MAX) ?
                            state_cur.crossing_count : state_cur.crossing_count + 8'd1;

    always_comb begin
        state_nxt = state_cur;
        flip      = 1'b0;
        if (crossing) begin
            if (!state_cur.window_armed) begin
                state_nxt.window_armed   = 1'b1;
                state_nxt.window_start   = item.time_s;
                state_nxt.crossing_count = 8'd0;
            end else if (window_expired) begin
                // stale window: restart it at this item
                state_nxt.window_start   = item.time_s;
                state_nxt.crossing_count = 8'd0;
            end else if (count_inc >= cfg.switch_count) begin
                flip                     = 1'b1;
                state_nxt.window_armed   = 1'b0;
                state_nxt.window_start   = 32'd0;
                state_nxt.crossing_count = 8'd0;
            end else begin
                state_nxt.crossing_count = count_inc;
            end
        end
        profile_new = state_cur.profile_bit ^ flip;
        state_nxt.profile_bit = profile_new;

        temp  = item.temperature;
        on_t  = profile_new ? cfg.sun_on_temp  : cfg.eclipse_on_temp;
        off_t = profile_new ? cfg.sun_off_temp : cfg.eclipse_off_temp;
        // "on" wins when the thresholds overlap
        if (temp < on_t) begin
            heater_new = 1'b1;
        end else if (temp > off_t) begin
            heater_new = 1'b0;
        end else begin
            heater_new = state_cur.heater_switch;
        end
        state_nxt.heater_switch = heater_new;

        result.heater_enable    = heater_new;
        result.sunshine_profile = profile_new;
    end

endmodule

// File: sv/heater_hysteresis_with_profile_core.sv
// Top level: heater thermostat with sunshine/eclipse profile selection.
//
// Input channel s_valid/s_ready/s_data carries one sample per item:
// temperature, solar power and time in seconds. Output channel
// m_valid/m_ready/m_data returns one item per sample: heater drive and
// profile after that sample, in input order.
// Samples land in an input register; the profile tracker and thermostat
// run combinationally from that register into the output register, and the
// state registers update at the same edge. An accepted sample moves from
// the input register to the output register, which drives m_valid; the
// throughput is one item per cycle while the receiver keeps m_ready high.
// The configuration port (cfg_wr_en, cfg_index, cfg_wdata) writes one
// register per cycle; indexes past the last register are ignored. Write
// only while no item is in flight.
// Reset (aresetn low, synchronous) loads the default thresholds, heater
// off, eclipse profile, window disarmed, and empties both stages.
// When the receiver stalls, the output item holds; the input register
// still takes one more item, after which s_ready drops until m_ready.
module heater_hysteresis_with_profile_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  hhp_pkg::hhp_in_t                     s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output hhp_pkg::hhp_out_t                    m_data,
    input  logic                                 cfg_wr_en,
    input  logic [hhp_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [hhp_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    hhp_pkg::hhp_cfg_t   cfg_reg;
    hhp_pkg::hhp_cfg_t   cfg_next;
    hhp_pkg::hhp_state_t state_reg;
    hhp_pkg::hhp_state_t state_next;
    hhp_pkg::hhp_in_t    in_data_reg;
    hhp_pkg::hhp_out_t   out_data_reg;
    hhp_pkg::hhp_out_t   out_data_next;
    logic                in_valid_reg;
    logic                out_valid_reg;
    logic                advance;
    logic                s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    hhp_update u_update (
        .cfg       (cfg_reg),
        .state_cur (state_reg),
        .item      (in_data_reg),
        .state_nxt (state_next),
        .result    (out_data_next)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                hhp_pkg::REG_SUN_ON_TEMP:        cfg_next.sun_on_temp        = cfg_wdata[7:0];
                hhp_pkg::REG_SUN_OFF_TEMP:       cfg_next.sun_off_temp       = cfg_wdata[7:0];
                hhp_pkg::REG_ECLIPSE_ON_TEMP:    cfg_next.eclipse_on_temp    = cfg_wdata[7:0];
                hhp_pkg::REG_ECLIPSE_OFF_TEMP:   cfg_next.eclipse_off_temp   = cfg_wdata[7:0];
                hhp_pkg::REG_POWER_THRESHOLD_MW: cfg_next.power_threshold_mw = cfg_wdata;
                hhp_pkg::REG_SWITCH_COUNT:       cfg_next.switch_count       = cfg_wdata[7:0];
                hhp_pkg::REG_TUMBLE_TIME_S:      cfg_next.tumble_time_s      = cfg_wdata;
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sun_on_temp        <= hhp_pkg::RST_SUN_ON_TEMP;
            cfg_reg.sun_off_temp       <= hhp_pkg::RST_SUN_OFF_TEMP;
            cfg_reg.eclipse_on_temp    <= hhp_pkg::RST_ECLIPSE_ON_TEMP;
            cfg_reg.eclipse_off_temp   <= hhp_pkg::RST_ECLIPSE_OFF_TEMP;
            cfg_reg.power_threshold_mw <= hhp_pkg::RST_POWER_THRESHOLD_MW;
            cfg_reg.switch_count       <= hhp_pkg::RST_SWITCH_COUNT;
            cfg_reg.tumble_time_s      <= hhp_pkg::RST_TUMBLE_TIME_S;
            state_reg                  <= '0;
            in_valid_reg               <= 1'b0;
            out_valid_reg              <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
            if (advance) begin
                state_reg <= state_next;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// File: sv/hhp_checker.sv
// Port-level checks for the heater core, bound to the top level.
module hhp_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input hhp_pkg::hhp_out_t m_data
);

    // a stalled result item holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output item changed while stalled");

    // input side only backs up when the output side is full and stalled
    a_backpressure_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("s_ready low without a stalled output item");

    // both stages full and stalled: nothing moves, so input opens only with m_ready
    a_full_stays_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready && !m_ready |=> m_valid && (s_ready == m_ready))
        else $error("s_ready changed with both stages full and no output taken");

    // an offered input item waits until it is taken
    a_in_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("s_valid dropped before the item was accepted");

endmodule

bind heater_hysteresis_with_profile_core hhp_checker u_hhp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
